FILE: hdl/tkid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkid_pkg: shared types and constants for the two-key id table
// Command and result words, the stored entry layout, command and status codes.
// ----------------------------------------------------------------------------
package tkid_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int KEY_W       = 32;
    localparam int ID_W        = 31;

    localparam logic signed [KEY_W-1:0] NO_ID = -32'sd1;

    typedef enum logic [1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2
    } t_command;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NO_IDS    = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [KEY_W-1:0] first_key;
        logic signed [KEY_W-1:0] second_key;
    } t_cmd_word;

    typedef struct packed {
        logic signed [KEY_W-1:0] entry_id;
        logic [1:0]              status;
    } t_result_word;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] first_key;
        logic [KEY_W-1:0] second_key;
        logic [ID_W-1:0]  id;
    } t_entry;

endpackage

FILE: hdl/tkid_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkid_cell: one table entry in the circulating ring
// Holds one entry and takes its neighbor's entry on every shift cycle.
// ----------------------------------------------------------------------------
module tkid_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  tkid_pkg::t_entry i_entry,
    output tkid_pkg::t_entry o_entry
);
    import tkid_pkg::*;

    t_entry r_entry;

    // Clear the valid bit on reset; advance the entry while the ring rotates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

FILE: hdl/two_key_id_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_key_id_table_core: associative id table keyed by a pair of 32-bit keys
// Find, insert and group delete over a ring of entry cells with one compare
// unit at the head of the ring.
// ----------------------------------------------------------------------------
// The table is a ring of TABLE_DEPTH cells; each pass rotates the ring once
// past a single compare unit, one entry per cycle, and the ring ends each
// command back in place. Find and delete strobe their result after one
// pass; an insert rotates the ring twice (look for the pair and a free
// slot, then write) and strobes after the second pass, unless the table
// is full, which is reported after the first. An insert with ids
// exhausted and an unknown command are answered in the cycle after they
// are taken. busy is high while the ring rotates; a new word may be
// started in the cycle the result strobes. Each result is on o_result for
// the single cycle that o_done is high and must be captured then: there is
// no backpressure.
module two_key_id_table_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  tkid_pkg::t_cmd_word   i_cmd,
    output logic                  o_done,
    output tkid_pkg::t_result_word o_result
);
    import tkid_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_DEPTH - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_step, n_step;
    t_cmd_word        r_req, n_req;
    logic             r_hit, n_hit;
    logic             r_free, n_free;
    logic             r_written, n_written;
    logic [ID_W-1:0]  r_found_id, n_found_id;
    logic [ID_W-1:0]  r_next_id, n_next_id;
    logic             r_done, n_done;
    t_result_word     r_result, n_result;

    t_entry           w_ring [TABLE_DEPTH];
    t_entry           w_head, w_head_back;
    logic [TABLE_DEPTH-1:0] w_valid;
    logic             w_shift, w_accept, w_last;
    logic             w_key1_eq, w_pair_hit, w_group_hit, w_take;

    // Ring of cells: each cell takes its upper neighbor, the top takes the head
    assign w_shift = (r_state == S_SCAN) || (r_state == S_APPLY);

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_ring
        t_entry w_in;
        if (g == TABLE_DEPTH - 1) begin : g_top
            assign w_in = w_head_back;
        end else begin : g_mid
            assign w_in = w_ring[g+1];
        end
        tkid_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_entry (w_in),
            .o_entry (w_ring[g])
        );
        assign w_valid[g] = w_ring[g].valid;
    end

    // Compare the entry at the head against the held request
    assign w_head      = w_ring[0];
    assign w_key1_eq   = (w_head.first_key == r_req.first_key);
    assign w_pair_hit  = w_head.valid && w_key1_eq && (w_head.second_key == r_req.second_key);
    assign w_group_hit = w_head.valid && w_key1_eq;
    assign w_last      = (r_step == LAST_STEP);
    assign w_accept    = start && !busy;

    // Write slot on the second pass: the matching pair, else the first free one
    assign w_take = (r_state == S_APPLY) && (r_req.command == CMD_INSERT) && !r_written
                    && ((r_hit && w_pair_hit) || (!r_hit && !w_head.valid));

    // Head update: write on insert, drop matches on delete, else pass through
    always_comb begin
        w_head_back = w_head;
        if (w_take) begin
            w_head_back.valid      = 1'b1;
            w_head_back.first_key  = r_req.first_key;
            w_head_back.second_key = r_req.second_key;
            w_head_back.id         = r_next_id;
        end else if ((r_state == S_SCAN) && (r_req.command == CMD_DELETE) && w_group_hit) begin
            w_head_back.valid = 1'b0;
        end
    end

    // Sequencer and result formation
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_req      = r_req;
        n_hit      = r_hit;
        n_free     = r_free;
        n_written  = r_written;
        n_found_id = r_found_id;
        n_next_id  = r_next_id;
        n_done     = 1'b0;
        n_result   = r_result;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req  = i_cmd;
                    n_hit  = 1'b0;
                    n_free = 1'b0;
                    n_step = '0;
                    if ((i_cmd.command == CMD_FIND) || (i_cmd.command == CMD_DELETE)) begin
                        n_state = S_SCAN;
                    end else if (i_cmd.command == CMD_INSERT) begin
                        if (&r_next_id) begin
                            n_done            = 1'b1;
                            n_result.entry_id = NO_ID;
                            n_result.status   = STAT_NO_IDS;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_done            = 1'b1;
                        n_result.entry_id = NO_ID;
                        n_result.status   = STAT_NOT_FOUND;
                    end
                end
            end
            S_SCAN: begin
                n_step = w_last ? '0 : r_step + 1'b1;
                if (r_req.command == CMD_DELETE) begin
                    n_hit = r_hit || w_group_hit;
                end else begin
                    n_hit = r_hit || w_pair_hit;
                end
                if (w_pair_hit && !r_hit) begin
                    n_found_id = w_head.id;
                end
                n_free = r_free || !w_head.valid;
                if (w_last) begin
                    if (r_req.command == CMD_INSERT) begin
                        if (n_hit || n_free) begin
                            n_state   = S_APPLY;
                            n_written = 1'b0;
                        end else begin
                            n_state           = S_IDLE;
                            n_done            = 1'b1;
                            n_result.entry_id = NO_ID;
                            n_result.status   = STAT_FULL;
                        end
                    end else begin
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                        n_result.status = n_hit ? STAT_OK : STAT_NOT_FOUND;
                        if ((r_req.command == CMD_FIND) && n_hit) begin
                            n_result.entry_id = {1'b0, n_found_id};
                        end else begin
                            n_result.entry_id = NO_ID;
                        end
                    end
                end
            end
            S_APPLY: begin
                n_step = w_last ? '0 : r_step + 1'b1;
                if (w_take) begin
                    n_written = 1'b1;
                end
                if (w_last) begin
                    n_state           = S_IDLE;
                    n_done            = 1'b1;
                    n_result.entry_id = {1'b0, r_next_id};
                    n_result.status   = STAT_OK;
                    n_next_id         = r_next_id + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_step  = '0;
            end
        endcase
    end

    // Hold control state under reset; payload registers load freely
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_written <= 1'b0;
            r_next_id <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_hit     <= n_hit;
            r_free    <= n_free;
            r_written <= n_written;
            r_next_id <= n_next_id;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_found_id <= n_found_id;
        r_result   <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // The ring is back in place whenever no command is in flight
    a_ring_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_step == '0))
        else $error("ring not aligned at idle");

    // A result word is only strobed with the sequencer back at idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_IDLE))
        else $error("result strobed while busy");

    // A full-table refusal means every cell holds a valid entry
    a_full_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == STAT_FULL)) |-> (&w_valid))
        else $error("full reported with a free slot");

    // A successful insert finishes only after its write has landed
    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == STAT_OK) && (r_req.command == CMD_INSERT))
        |-> r_written)
        else $error("insert finished without a write");

endmodule
